// ===== hdl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the schoolbook multiprecision multiplier.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int MAX_WORDS_DEF     = 16;
  localparam int MAX_WORD_BITS_DEF = 32;

  localparam int DIGIT_W  = 32;
  localparam int WBITS_W  = 6;
  localparam int WORDS_W  = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [WBITS_W-1:0] WORD_BITS_RST    = 6'd32;
  localparam logic [WORDS_W-1:0] WORDS_IN_USE_RST = 5'd16;

  typedef enum logic [0:0] {
    REG_WORD_BITS    = 1'b0,
    REG_WORDS_IN_USE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] a_digit;
    logic [DIGIT_W-1:0] b_digit;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] product_digit;
    logic               digit_last;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic zero_b;
    logic zero_prod;
  } mac_ctl_t;

endpackage

// ===== hdl/mpsm_cfg.sv =====
// ----------------------------------------------------------------------------
// mpsm_cfg
// Register file on the APB-style port; derives effective digit width,
// digit count and digit mask.
// ----------------------------------------------------------------------------
module mpsm_cfg #(
  parameter int MAX_WORDS     = mpsm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_BITS = mpsm_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mpsm_pkg::PADDR_W-1:0]      paddr,
  input  logic [mpsm_pkg::PDATA_W-1:0]      pwdata,
  output logic [mpsm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic [mpsm_pkg::WBITS_W-1:0]      w_eff,
  output logic [mpsm_pkg::WORDS_W-1:0]      t_eff,
  output logic [MAX_WORD_BITS-1:0]          mask
);

  logic [mpsm_pkg::WBITS_W-1:0] word_bits_r;
  logic [mpsm_pkg::WORDS_W-1:0] words_in_use_r;
  mpsm_pkg::reg_idx_t           idx;
  logic                         wr_en;
  logic [MAX_WORD_BITS:0]       mask_full;

  assign pready = 1'b1;
  assign idx    = mpsm_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_bits_r    <= mpsm_pkg::WORD_BITS_RST;
      words_in_use_r <= mpsm_pkg::WORDS_IN_USE_RST;
    end else if (wr_en) begin
      case (idx)
        mpsm_pkg::REG_WORD_BITS:    word_bits_r    <= pwdata[mpsm_pkg::WBITS_W-1:0];
        mpsm_pkg::REG_WORDS_IN_USE: words_in_use_r <= pwdata[mpsm_pkg::WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mpsm_pkg::REG_WORD_BITS:    prdata = mpsm_pkg::PDATA_W'(word_bits_r);
      mpsm_pkg::REG_WORDS_IN_USE: prdata = mpsm_pkg::PDATA_W'(words_in_use_r);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    if (word_bits_r == '0)
      w_eff = mpsm_pkg::WBITS_W'(1);
    else if (word_bits_r > mpsm_pkg::WBITS_W'(MAX_WORD_BITS))
      w_eff = mpsm_pkg::WBITS_W'(MAX_WORD_BITS);
    else
      w_eff = word_bits_r;

    if (words_in_use_r == '0)
      t_eff = mpsm_pkg::WORDS_W'(1);
    else if (words_in_use_r > mpsm_pkg::WORDS_W'(MAX_WORDS))
      t_eff = mpsm_pkg::WORDS_W'(MAX_WORDS);
    else
      t_eff = words_in_use_r;
  end

  assign mask_full = ((MAX_WORD_BITS+1)'(1) << w_eff) - (MAX_WORD_BITS+1)'(1);
  assign mask      = mask_full[MAX_WORD_BITS-1:0];

endmodule

// ===== hdl/mpsm_opmem.sv =====
// ----------------------------------------------------------------------------
// mpsm_opmem
// Operand digit stores: one write port for loading, one registered read
// port each for the row and column digit.
// ----------------------------------------------------------------------------
module mpsm_opmem #(
  parameter int MAX_WORDS     = mpsm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_BITS = mpsm_pkg::MAX_WORD_BITS_DEF,
  parameter int AW            = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  mpsm_pkg::in_item_t       wdata,
  input  logic [MAX_WORD_BITS-1:0] mask,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic [MAX_WORD_BITS-1:0] a_q,
  output logic [MAX_WORD_BITS-1:0] b_q
);

  logic [MAX_WORD_BITS-1:0] a_mem [MAX_WORDS];
  logic [MAX_WORD_BITS-1:0] b_mem [MAX_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      a_mem[waddr] <= wdata.a_digit[MAX_WORD_BITS-1:0] & mask;
      b_mem[waddr] <= wdata.b_digit[MAX_WORD_BITS-1:0] & mask;
    end
    a_q <= a_mem[raddr_a];
    b_q <= b_mem[raddr_b];
  end

endmodule

// ===== hdl/mpsm_prodmem.sv =====
// ----------------------------------------------------------------------------
// mpsm_prodmem
// Product digit store: one write port, one registered read port, with
// write data forwarded when both ports hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module mpsm_prodmem #(
  parameter int MAX_WORDS     = mpsm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_BITS = mpsm_pkg::MAX_WORD_BITS_DEF,
  parameter int PW            = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [PW-1:0]            waddr,
  input  logic [MAX_WORD_BITS-1:0] wdata,
  input  logic [PW-1:0]            raddr,
  output logic [MAX_WORD_BITS-1:0] rdata_q
);

  logic [MAX_WORD_BITS-1:0] mem [2*MAX_WORDS];

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    if (we && (waddr == raddr))
      rdata_q <= wdata;
    else
      rdata_q <= mem[raddr];
  end

endmodule

// ===== hdl/mpsm_mac.sv =====
// ----------------------------------------------------------------------------
// mpsm_mac
// Multiply-accumulate pipeline: multiply stage, then add of product,
// stored digit and running carry, split into low digit and carry.
// ----------------------------------------------------------------------------
module mpsm_mac #(
  parameter int MAX_WORD_BITS = mpsm_pkg::MAX_WORD_BITS_DEF,
  parameter int PW            = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpsm_pkg::mac_ctl_t            ctl0,
  input  logic [PW-1:0]                 addr0,
  input  logic [MAX_WORD_BITS-1:0]      a_q,
  input  logic [MAX_WORD_BITS-1:0]      b_q,
  input  logic [MAX_WORD_BITS-1:0]      p_q,
  input  logic [MAX_WORD_BITS-1:0]      mask,
  input  logic [mpsm_pkg::WBITS_W-1:0]  w_eff,
  output logic                          we,
  output logic [PW-1:0]                 waddr,
  output logic [MAX_WORD_BITS-1:0]      wdata
);

  localparam int PROD_W = 2 * MAX_WORD_BITS;

  mpsm_pkg::mac_ctl_t       ctl1_r, ctl2_r;
  logic [PW-1:0]            addr1_r, addr2_r;
  logic [MAX_WORD_BITS-1:0] a_m, b_m;
  logic [PROD_W-1:0]        mul_r;
  logic [MAX_WORD_BITS-1:0] prod_r;
  logic [MAX_WORD_BITS-1:0] carry_r;
  logic [MAX_WORD_BITS-1:0] carry_in;
  logic [PROD_W-1:0]        sum;
  logic [PROD_W-1:0]        sum_sh;

  assign a_m = a_q & mask;
  assign b_m = ctl1_r.zero_b ? '0 : (b_q & mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl0;
      ctl2_r <= ctl1_r;
    end
    addr1_r <= addr0;
    addr2_r <= addr1_r;
    mul_r   <= PROD_W'(a_m) * PROD_W'(b_m);
    prod_r  <= ctl1_r.zero_prod ? '0 : (p_q & mask);
    if (ctl2_r.valid)
      carry_r <= sum_sh[MAX_WORD_BITS-1:0];
  end

  assign carry_in = ctl2_r.first ? '0 : carry_r;
  assign sum      = mul_r + PROD_W'(prod_r) + PROD_W'(carry_in);
  assign sum_sh   = sum >> w_eff;

  assign we    = ctl2_r.valid;
  assign waddr = addr2_r;
  assign wdata = sum[MAX_WORD_BITS-1:0] & mask;

endmodule

// ===== hdl/mpsm_seq.sv =====
// ----------------------------------------------------------------------------
// mpsm_seq
// Sequencer: operand loading, row-by-row issue of multiply-accumulate
// steps and read-out of the product digits.
// ----------------------------------------------------------------------------
module mpsm_seq #(
  parameter int MAX_WORDS = mpsm_pkg::MAX_WORDS_DEF,
  parameter int AW        = 4,
  parameter int CNT_W     = 5,
  parameter int PW        = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mpsm_pkg::WORDS_W-1:0] t_eff,
  output logic                         busy,
  output logic                         ld_we,
  output logic [AW-1:0]                ld_addr,
  output logic [AW-1:0]                ra_addr,
  output logic [AW-1:0]                rb_addr,
  output logic [PW-1:0]                p_raddr,
  output mpsm_pkg::mac_ctl_t           ctl0,
  output logic                         out_valid_r,
  output logic                         out_last_r
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_MAC,
    S_OUT
  } state_t;

  state_t     state_r;
  logic [CNT_W-1:0] load_cnt_r;
  logic [CNT_W-1:0] cnt_inc;
  logic [AW-1:0]    i_r;
  logic [CNT_W-1:0] j_r;
  logic [PW-1:0]    k_r;
  logic             accept;
  logic             load_done;
  logic             row_end;
  logic             last_row;
  logic             k_last;

  assign busy      = (state_r != S_LOAD);
  assign accept    = start & ~busy;
  assign cnt_inc   = load_cnt_r + CNT_W'(1);
  assign load_done = (mpsm_pkg::WORDS_W'(cnt_inc) >= t_eff);
  assign ld_we     = accept && (load_cnt_r < CNT_W'(MAX_WORDS));
  assign ld_addr   = load_cnt_r[AW-1:0];

  assign row_end  = (mpsm_pkg::WORDS_W'(j_r) == t_eff);
  assign last_row = (mpsm_pkg::WORDS_W'(i_r) == t_eff - mpsm_pkg::WORDS_W'(1));
  assign k_last   = ((mpsm_pkg::WORDS_W + 1)'(k_r) ==
                     {t_eff, 1'b0} - (mpsm_pkg::WORDS_W + 1)'(1));

  assign ra_addr = i_r;
  assign rb_addr = row_end ? '0 : j_r[AW-1:0];

  always_comb begin
    ctl0 = '0;
    if (state_r == S_OUT) begin
      p_raddr = k_r;
    end else begin
      p_raddr = PW'(i_r) + PW'(j_r);
    end
    if (state_r == S_MAC) begin
      ctl0.valid     = 1'b1;
      ctl0.first     = (j_r == '0);
      ctl0.zero_b    = row_end;
      ctl0.zero_prod = row_end || (i_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (load_done) begin
              load_cnt_r <= '0;
              i_r        <= '0;
              j_r        <= '0;
              state_r    <= S_MAC;
            end else begin
              load_cnt_r <= cnt_inc;
            end
          end
        end
        S_MAC: begin
          if (row_end) begin
            j_r <= '0;
            if (last_row) begin
              k_r     <= '0;
              state_r <= S_OUT;
            end else begin
              i_r <= i_r + AW'(1);
            end
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= k_last;
          if (k_last) begin
            state_r <= S_LOAD;
          end else begin
            k_r <= k_r + PW'(1);
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== hdl/multiprecision_schoolbook_multiply.sv =====
// ----------------------------------------------------------------------------
// multiprecision_schoolbook_multiply
// Schoolbook multiplier of two t-digit numbers in radix 2^w; operand digits
// enter in pairs, the 2t product digits leave least significant first.
//
//   channel  ports                               handshake
//   input    start, busy, in_item                taken when start & !busy
//   result   out_valid, out_item                 one-cycle strobe, no stall
//   config   psel, penable, pwrite, paddr, ...   APB write, pready tied high
//
// A digit pair that does not complete the operands leaves the input open.
// The t-th pair starts the multiply-accumulate pass (one row of t+1
// steps per operand digit) and the read-out of the 2t product digits,
// all through the single read port of the product store; busy stays
// high until the last digit is read.
// Synchronous reset clears control only; no clearing pass on the stores.
// ----------------------------------------------------------------------------
module multiprecision_schoolbook_multiply #(
  parameter int MAX_WORDS     = mpsm_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_BITS = mpsm_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  mpsm_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output mpsm_pkg::out_item_t          out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpsm_pkg::PADDR_W-1:0] paddr,
  input  logic [mpsm_pkg::PDATA_W-1:0] pwdata,
  output logic [mpsm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int PW    = $clog2(2 * MAX_WORDS);

  logic [mpsm_pkg::WBITS_W-1:0] w_eff;
  logic [mpsm_pkg::WORDS_W-1:0] t_eff;
  logic [MAX_WORD_BITS-1:0]     mask;
  logic                         ld_we;
  logic [AW-1:0]                ld_addr, ra_addr, rb_addr;
  logic [PW-1:0]                p_raddr, p_waddr;
  mpsm_pkg::mac_ctl_t           ctl0;
  logic [MAX_WORD_BITS-1:0]     a_q, b_q, p_q, p_wdata;
  logic                         p_we;
  logic                         out_last;

  mpsm_cfg #(
    .MAX_WORDS     (MAX_WORDS),
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_eff   (w_eff),
    .t_eff   (t_eff),
    .mask    (mask)
  );

  mpsm_seq #(
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW),
    .CNT_W     (CNT_W),
    .PW        (PW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .t_eff       (t_eff),
    .busy        (busy),
    .ld_we       (ld_we),
    .ld_addr     (ld_addr),
    .ra_addr     (ra_addr),
    .rb_addr     (rb_addr),
    .p_raddr     (p_raddr),
    .ctl0        (ctl0),
    .out_valid_r (out_valid),
    .out_last_r  (out_last)
  );

  mpsm_opmem #(
    .MAX_WORDS     (MAX_WORDS),
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .AW            (AW)
  ) u_opmem (
    .clk     (clk),
    .we      (ld_we),
    .waddr   (ld_addr),
    .wdata   (in_item),
    .mask    (mask),
    .raddr_a (ra_addr),
    .raddr_b (rb_addr),
    .a_q     (a_q),
    .b_q     (b_q)
  );

  mpsm_mac #(
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .PW            (PW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl0  (ctl0),
    .addr0 (p_raddr),
    .a_q   (a_q),
    .b_q   (b_q),
    .p_q   (p_q),
    .mask  (mask),
    .w_eff (w_eff),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata)
  );

  mpsm_prodmem #(
    .MAX_WORDS     (MAX_WORDS),
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .PW            (PW)
  ) u_prodmem (
    .clk     (clk),
    .we      (p_we),
    .waddr   (p_waddr),
    .wdata   (p_wdata),
    .raddr   (p_raddr),
    .rdata_q (p_q)
  );

  assign out_item.product_digit = mpsm_pkg::DIGIT_W'(p_q);
  assign out_item.digit_last    = out_last;

endmodule

// ===== hdl/mpsm_checker.sv =====
// ----------------------------------------------------------------------------
// mpsm_checker
// Port-level checks of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mpsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input mpsm_pkg::out_item_t out_item,
  input logic                pready
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  a_digits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.digit_last) |=> out_valid)
    else $error("gap inside a product digit burst");

  a_busy_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.digit_last) |-> busy)
    else $error("input open before final digit");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.digit_last) |=> !out_valid)
    else $error("digit follows the final digit");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind multiprecision_schoolbook_multiply mpsm_checker u_mpsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item),
  .pready    (pready)
);
